// ----- rtl/glyph_row_repacker_macros.svh -----
//------------------------------------------------------------------------------
// glyph_row_repacker_macros.svh
// Assertion macros shared by the repacker checker.
//------------------------------------------------------------------------------
`ifndef GLYPH_ROW_REPACKER_MACROS_SVH
`define GLYPH_ROW_REPACKER_MACROS_SVH

// same-cycle implication, off while reset is high
`define GRR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("repacker assertion failed");

// next-cycle implication, off while reset is high
`define GRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("repacker assertion failed");

// next-cycle implication that also covers reset itself
`define GRR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("repacker assertion failed");

`endif

// ----- rtl/grr_pkg.sv -----
//------------------------------------------------------------------------------
// grr_pkg
// Shared types and constants of the glyph row repacker.
//------------------------------------------------------------------------------
package grr_pkg;

   localparam int ByteW       = 8;
   localparam int CsrIdxW     = 2;
   localparam int BprW        = 4;
   localparam int RowsW       = 8;
   localparam int MarginW     = 4;
   localparam int IdxW        = 11;
   localparam int ZeroCntW    = 6;   // up to 4 rows x 8 bytes
   localparam int BeatCntW    = 7;   // up to 32 + 2 + 32 beats per item
   localparam int CmdFifoDepth = 4;
   localparam int CmdPtrW     = $clog2(CmdFifoDepth);

   localparam logic [BprW-1:0]    BprReset    = 4'd1;
   localparam logic [RowsW-1:0]   RowsReset   = 8'd16;
   localparam logic [MarginW-1:0] MarginReset = 4'd0;
   localparam logic [BprW-1:0]    BprMax      = 4'd8;
   localparam logic [MarginW-1:0] MarginMax   = 4'd8;
   localparam logic [BprW-1:0]    PackBpr     = 4'd2;
   localparam logic [ByteW-1:0]   HiNibble    = 8'hF0;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BYTES_PER_ROW = 2'd0,
      CSR_GLYPH_ROWS    = 2'd1,
      CSR_MARGIN_ROWS   = 2'd2,
      CSR_PACK_MODE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                we;
      logic [CsrIdxW-1:0]  index;
      logic [ByteW-1:0]    data;
   } csr_write_type;

   // one classified input byte: what the back end must emit for it
   typedef struct packed {
      logic [ZeroCntW-1:0] top_zeros;   // blank bytes before the data
      logic [ByteW-1:0]    data0;
      logic [ByteW-1:0]    data1;
      logic                two_data;    // pack mode, third byte of a triple
      logic [BeatCntW-1:0] last_beat;   // index of the final beat
      logic                glyph_done;
   } cmd_type;

endpackage

// ----- rtl/glyph_row_repacker.sv -----
//------------------------------------------------------------------------------
// glyph_row_repacker
// Pads bitmap font glyph rows with blank margin rows, optional 12-pixel repack.
//------------------------------------------------------------------------------
// Usage: each accepted byte yields one or more output beats; a front end
// classifies the byte into a command (leading blank bytes, one or two data
// bytes, trailing blank bytes) and pushes it into a 4-deep command queue, so
// input is taken at one byte per cycle as long as the queue has room. The back
// end emits one beat per cycle into a registered output stage while rsp_ready
// does not hold it, so an item with N results yields N beats (N = 1 .. 33:
// top margin floor(m/2)*bpr on the first byte of a glyph, data 1 or 2, bottom
// margin ceil(m/2)*bpr on the last byte; only a one-byte glyph carries both).
// The first beat of a byte passes the queue entry, then the command register,
// then the output register before it shows on rsp_valid. Sustained rate is
// one item per cycle while each item has a single result and rsp_ready stays
// high; bytes that carry margin rows, and the third byte of a packed triple
// (two data beats), hold the back end for their beat count, and req_ready
// drops once four commands are waiting. Configuration writes restart the
// glyph and belong only to idle periods.
module glyph_row_repacker (
   input  logic       clock,
   input  logic       reset,
   // input beats
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   // output beats
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_glyph_end,
   // register writes
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import grr_pkg::*;

   csr_write_type csr;
   cmd_type       push_cmd;
   cmd_type       pop_cmd;
   logic          cmd_push;
   logic          cmd_full;
   logic          cmd_pop;
   logic          cmd_avail;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   // front: glyph position, pack phase, config registers
   grr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .cmd_full    (cmd_full)
   );

   // decouples input stalls from margin bursts
   grr_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_cmd   (pop_cmd),
      .not_empty (cmd_avail)
   );

   // back: beat sequencer and output register
   grr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_avail     (cmd_avail),
      .cmd_in        (pop_cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_glyph_end (rsp_glyph_end)
   );

endmodule

// ----- rtl/grr_front.sv -----
//------------------------------------------------------------------------------
// grr_front
// Takes input bytes, tracks glyph position and turns each byte into a command.
//------------------------------------------------------------------------------
module grr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  grr_pkg::csr_write_type csr,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   output logic                  cmd_push,
   output grr_pkg::cmd_type      cmd,
   input  logic                  cmd_full
);
   import grr_pkg::*;

   logic [BprW-1:0]    bpr_ff, bpr_in;
   logic [RowsW-1:0]   rows_ff, rows_in;
   logic [MarginW-1:0] margin_ff, margin_in;
   logic               pack_ff, pack_in;
   logic [IdxW-1:0]    byte_index_ff, byte_index_in;
   logic [ByteW-1:0]   held_byte_ff, held_byte_in;
   logic [1:0]         phase_ff, phase_in;

   logic [BprW-1:0]     eff_bpr;
   logic [RowsW:0]      eff_rows;
   logic [RowsW:0]      rows_nz;
   logic [MarginW-1:0]  eff_margin;
   logic [MarginW:0]    margin_up;
   logic [ZeroCntW-1:0] top_zeros;
   logic [ZeroCntW-1:0] bot_zeros;
   logic [IdxW-1:0]     total;
   logic [IdxW-1:0]     idx_next;
   logic                ends;
   logic                accept;

   assign req_ready = !cmd_full;
   assign accept    = req_valid && req_ready;
   assign cmd_push  = accept;

   // effective geometry
   always_comb begin
      if (pack_ff) begin
         eff_bpr = PackBpr;
      end else if (bpr_ff == '0) begin
         eff_bpr = BprW'(1);
      end else if (bpr_ff > BprMax) begin
         eff_bpr = BprMax;
      end else begin
         eff_bpr = bpr_ff;
      end
      rows_nz = (rows_ff == '0) ? (RowsW+1)'(1) : {1'b0, rows_ff};
      eff_rows = (pack_ff && rows_nz[0]) ? rows_nz + (RowsW+1)'(1) : rows_nz;
      eff_margin = (margin_ff > MarginMax) ? MarginMax : margin_ff;
      margin_up = {1'b0, eff_margin} + (MarginW+1)'(1);
      top_zeros = ZeroCntW'(eff_margin[MarginW-1:1]) * ZeroCntW'(eff_bpr);
      bot_zeros = ZeroCntW'(margin_up[MarginW:1]) * ZeroCntW'(eff_bpr);
      total = pack_ff ? IdxW'(eff_rows[RowsW:1]) * IdxW'(3)
                      : IdxW'(eff_bpr) * IdxW'(eff_rows);
   end

   assign idx_next = byte_index_ff + IdxW'(1);
   assign ends     = (idx_next >= total) || (idx_next == '0);

   // classify the byte
   always_comb begin
      cmd.top_zeros  = (byte_index_ff == '0) ? top_zeros : '0;
      cmd.data0      = req_in_byte;
      cmd.data1      = '0;
      cmd.two_data   = 1'b0;
      cmd.glyph_done = ends;
      held_byte_in   = held_byte_ff;
      phase_in       = phase_ff;
      if (pack_ff) begin
         case (phase_ff)
            2'd1: begin
               cmd.data0    = req_in_byte & HiNibble;
               held_byte_in = req_in_byte;
               phase_in     = 2'd2;
            end
            2'd2: begin
               cmd.data0    = {held_byte_ff[3:0], req_in_byte[7:4]};
               cmd.data1    = {req_in_byte[3:0], 4'h0};
               cmd.two_data = 1'b1;
               phase_in     = 2'd0;
            end
            default: begin
               held_byte_in = req_in_byte;
               phase_in     = 2'd1;
            end
         endcase
      end
      cmd.last_beat = BeatCntW'(cmd.top_zeros)
                    + (cmd.two_data ? BeatCntW'(1) : BeatCntW'(0))
                    + (ends ? BeatCntW'(bot_zeros) : BeatCntW'(0));
      byte_index_in = idx_next;
      if (ends) begin
         byte_index_in = '0;
         held_byte_in  = '0;
         phase_in      = 2'd0;
      end
   end

   // config writes
   always_comb begin
      bpr_in    = bpr_ff;
      rows_in   = rows_ff;
      margin_in = margin_ff;
      pack_in   = pack_ff;
      case (csr_index_type'(csr.index))
         CSR_BYTES_PER_ROW: bpr_in    = csr.data[BprW-1:0];
         CSR_GLYPH_ROWS:    rows_in   = csr.data[RowsW-1:0];
         CSR_MARGIN_ROWS:   margin_in = csr.data[MarginW-1:0];
         CSR_PACK_MODE:     pack_in   = csr.data[0];
         default:           bpr_in    = bpr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff        <= BprReset;
         rows_ff       <= RowsReset;
         margin_ff     <= MarginReset;
         pack_ff       <= 1'b0;
         byte_index_ff <= '0;
         held_byte_ff  <= '0;
         phase_ff      <= 2'd0;
      end else if (csr.we) begin
         // any write restarts the glyph
         bpr_ff        <= bpr_in;
         rows_ff       <= rows_in;
         margin_ff     <= margin_in;
         pack_ff       <= pack_in;
         byte_index_ff <= '0;
         held_byte_ff  <= '0;
         phase_ff      <= 2'd0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         held_byte_ff  <= held_byte_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

// ----- rtl/grr_cmd_fifo.sv -----
//------------------------------------------------------------------------------
// grr_cmd_fifo
// Short command queue between the front and back ends.
//------------------------------------------------------------------------------
module grr_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  grr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output grr_pkg::cmd_type pop_cmd,
   output logic             not_empty
);
   import grr_pkg::*;

   cmd_type              entry_ff [CmdFifoDepth];
   logic [CmdPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CmdPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CmdPtrW:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == (CmdPtrW+1)'(CmdFifoDepth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CmdPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + CmdPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (CmdPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (CmdPtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/grr_back.sv -----
//------------------------------------------------------------------------------
// grr_back
// Expands commands into output beats through a registered output stage.
//------------------------------------------------------------------------------
module grr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_avail,
   input  grr_pkg::cmd_type cmd_in,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_glyph_end
);
   import grr_pkg::*;

   cmd_type             cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [BeatCntW-1:0] beat_ff, beat_in;
   logic                out_valid_ff, out_valid_in;
   logic [ByteW-1:0]    out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic                out_end_ff, out_end_in;

   logic                advance;
   logic                last_beat;
   logic [ByteW-1:0]    beat_byte;

   assign advance   = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign last_beat = (beat_ff == cur_ff.last_beat);
   assign cmd_pop   = cmd_avail && (!cur_valid_ff || (advance && last_beat));

   // zeros, then data, then zeros
   always_comb begin
      if (beat_ff == BeatCntW'(cur_ff.top_zeros)) begin
         beat_byte = cur_ff.data0;
      end else if (cur_ff.two_data
                   && beat_ff == BeatCntW'(cur_ff.top_zeros) + BeatCntW'(1)) begin
         beat_byte = cur_ff.data1;
      end else begin
         beat_byte = '0;
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      beat_in      = beat_ff;
      if (advance && !last_beat) begin
         beat_in = beat_ff + BeatCntW'(1);
      end else if (advance) begin
         cur_valid_in = 1'b0;
      end
      if (cmd_pop) begin
         cur_in       = cmd_in;
         cur_valid_in = 1'b1;
         beat_in      = '0;
      end

      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = beat_byte;
         out_last_in  = last_beat;
         out_end_in   = last_beat && cur_ff.glyph_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = out_last_ff;
   assign rsp_glyph_end = out_end_ff;

endmodule

// ----- rtl/grr_checker.sv -----
//------------------------------------------------------------------------------
// grr_checker
// Port-level checks on the glyph row repacker, bound to the top level.
//------------------------------------------------------------------------------
`include "glyph_row_repacker_macros.svh"

module grr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_glyph_end
);

   // no beat right out of reset
   `GRR_ASSERT_NEXT_ALWAYS(a_no_beat_after_reset, clock, reset, !rsp_valid)

   // glyph end closes the run of its input byte
   `GRR_ASSERT_NOW(a_end_is_run_last, clock, reset, rsp_valid && rsp_glyph_end, rsp_run_last)

   // stalled beat holds
   `GRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last) && $stable(rsp_glyph_end))

endmodule

bind glyph_row_repacker grr_checker u_grr_checker (.*);
